// ----- hw/rtl/bmssc_pkg.sv -----
// Shared types, constants and helpers for the bounded subarray-sum counter.
package bmssc_pkg;

    localparam int SEGMENT_DEPTH = 256;
    localparam int ELEM_W        = 32;
    localparam int TARGET_W      = 40;
    localparam int TALLY_W       = 48;
    localparam int FILL_W        = $clog2(SEGMENT_DEPTH + 1);
    localparam int HITS_W        = $clog2(SEGMENT_DEPTH + 2);
    localparam int PREFIX_W      = ELEM_W + FILL_W;
    localparam int WANT_W        = ((PREFIX_W > TARGET_W) ? PREFIX_W : TARGET_W) + 1;
    localparam int CFG_INDEX_W   = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_SUM = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_BOUND  = 1'd1;

    typedef struct packed {
        logic signed [ELEM_W-1:0] element_value;
        logic                     is_final;
    } in_item_t;

    typedef struct packed {
        logic [TALLY_W-1:0] match_count;
        logic               segment_overflow;
    } out_item_t;

    // Token that walks the cell chain, carrying the running match count.
    typedef struct packed {
        logic              tok;
        logic [HITS_W-1:0] hits;
    } tok_t;

    function automatic logic [WANT_W-1:0] sext_prefix(input logic [PREFIX_W-1:0] x);
        return {{(WANT_W - PREFIX_W){x[PREFIX_W-1]}}, x};
    endfunction

    function automatic logic [WANT_W-1:0] sext_target(input logic [TARGET_W-1:0] x);
        return {{(WANT_W - TARGET_W){x[TARGET_W-1]}}, x};
    endfunction

endpackage

// ----- hw/rtl/bmssc_cell.sv -----
// One cell of the prefix chain: a stored prefix, its comparator and a token stage.
module bmssc_cell (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 shift_en,
    input  logic        [bmssc_pkg::PREFIX_W-1:0] shift_in,
    output logic        [bmssc_pkg::PREFIX_W-1:0] shift_out,
    input  logic        [bmssc_pkg::WANT_W-1:0]   want,
    input  logic                                 live,
    input  bmssc_pkg::tok_t                      tok_in,
    output bmssc_pkg::tok_t                      tok_out
);

    logic [bmssc_pkg::PREFIX_W-1:0] prefix_reg;
    logic                           tok_reg;
    logic [bmssc_pkg::HITS_W-1:0]   hits_reg;
    logic [bmssc_pkg::HITS_W-1:0]   hits_next;
    logic                           match;

    // The stored prefix only counts when this cell lies below the fill level.
    assign match     = live && (bmssc_pkg::sext_prefix(prefix_reg) == want);
    assign hits_next = tok_in.hits + bmssc_pkg::HITS_W'(tok_in.tok && match);

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            prefix_reg <= shift_in;
        end
        hits_reg <= hits_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_in.tok;
        end
    end

    assign shift_out    = prefix_reg;
    assign tok_out.tok  = tok_reg;
    assign tok_out.hits = hits_reg;

endmodule

// ----- hw/rtl/bounded_max_subarray_sum_counter.sv -----
// Top level of the bounded subarray-sum counter: control, registers and the cell chain.
//
//   Channel  Handshake               Payload
//   in       in_valid / in_ready     in_data    (element_value, is_final)
//   out      out_valid / out_ready   out_data   (match_count, segment_overflow)
//   cfg      cfg_valid / cfg_ready   cfg_index, cfg_data (target_sum, max_bound)
//
// An element that is compared against the stored prefixes passes through PREP, SCAN
// and FINISH: in SCAN the match token walks the chain one cell per cycle. An element
// above the bound, or one in a frozen segment, goes straight to FINISH.
// Reset clears all control state at once; there is no clearing pass, and the
// prefix cells are only read below the fill level. A final element whose result
// finds the output register still occupied waits until out_ready frees it; a
// pending result never blocks the next input transaction.
module bounded_max_subarray_sum_counter (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  bmssc_pkg::in_item_t                      in_data,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output bmssc_pkg::out_item_t                     out_data,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic        [bmssc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic        [bmssc_pkg::TARGET_W-1:0]    cfg_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_PREP   = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam int DEPTH = bmssc_pkg::SEGMENT_DEPTH;
    localparam int PW    = bmssc_pkg::PREFIX_W;
    localparam int FW    = bmssc_pkg::FILL_W;
    localparam int HW    = bmssc_pkg::HITS_W;
    localparam int TW    = bmssc_pkg::TALLY_W;

    // Control state.
    logic [1:0]                        state_reg, state_next;
    logic signed [bmssc_pkg::TARGET_W-1:0] target_reg, target_next;
    logic signed [bmssc_pkg::ELEM_W-1:0]   bound_reg, bound_next;
    logic [FW-1:0]                     fill_level_reg, fill_level_next;
    logic [PW-1:0]                     running_reg, running_next;
    logic [TW-1:0]                     tally_reg, tally_next;
    logic                              overflow_reg, overflow_next;
    logic                              frozen_reg, frozen_next;
    logic                              launch_reg, launch_next;
    logic                              out_valid_reg, out_valid_next;

    // Per-element working registers.
    logic [PW-1:0]                     p_reg, p_next;
    logic [bmssc_pkg::WANT_W-1:0]      want_reg, want_next;
    logic [HW-1:0]                     hits_reg, hits_next;
    logic                              last_reg, last_next;
    logic                              update_reg, update_next;
    logic                              above_reg, above_next;
    bmssc_pkg::out_item_t              out_data_reg, out_data_next;

    logic                              in_fire;
    logic                              fire;
    logic                              store_ok;
    logic                              shift_en;
    logic                              above;
    logic [TW:0]                       tally_sum;
    logic [TW-1:0]                     tally_new;
    logic                              overflow_new;

    bmssc_pkg::tok_t                   tok_chain [0:DEPTH];
    logic [PW-1:0]                     pre_chain [0:DEPTH-1];
    logic [DEPTH-1:0]                  live;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign above = in_data.element_value > bound_reg;

    // The finishing step fires unless a final result has nowhere to go yet.
    assign fire     = (state_reg == ST_FINISH) && (!last_reg || !out_valid_reg || out_ready);
    assign store_ok = update_reg && (fill_level_reg < FW'(DEPTH));
    assign shift_en = fire && store_ok;

    // Saturating tally update; hits stays zero for elements that do not compare.
    assign tally_sum    = {1'b0, tally_reg} + (TW + 1)'(hits_reg);
    assign tally_new    = tally_sum[TW] ? {TW{1'b1}} : tally_sum[TW-1:0];
    assign overflow_new = overflow_reg || (update_reg && !store_ok);

    always_comb
    begin
        state_next      = state_reg;
        target_next     = target_reg;
        bound_next      = bound_reg;
        fill_level_next = fill_level_reg;
        running_next    = running_reg;
        tally_next      = tally_reg;
        overflow_next   = overflow_reg;
        frozen_next     = frozen_reg;
        launch_next     = 1'b0;
        out_valid_next  = out_valid_reg && !out_ready;
        p_next          = p_reg;
        want_next       = want_reg;
        hits_next       = hits_reg;
        last_next       = last_reg;
        update_next     = update_reg;
        above_next      = above_reg;
        out_data_next   = out_data_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                bmssc_pkg::CFG_TARGET_SUM: target_next = cfg_data;
                bmssc_pkg::CFG_MAX_BOUND:  bound_next  = cfg_data[bmssc_pkg::ELEM_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    last_next   = in_data.is_final;
                    above_next  = above;
                    update_next = !above && !frozen_reg;
                    hits_next   = '0;
                    p_next      = running_reg
                                + {{(PW - bmssc_pkg::ELEM_W){in_data.element_value[31]}},
                                   in_data.element_value};
                    state_next  = (!above && !frozen_reg) ? ST_PREP : ST_FINISH;
                end
            end
            ST_PREP:
            begin
                // The whole segment so far is a match when the prefix equals the target.
                want_next   = bmssc_pkg::sext_prefix(p_reg) - bmssc_pkg::sext_target(target_reg);
                hits_next   = HW'(bmssc_pkg::sext_prefix(p_reg)
                                  == bmssc_pkg::sext_target(target_reg));
                launch_next = 1'b1;
                state_next  = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (tok_chain[DEPTH].tok)
                begin
                    hits_next  = tok_chain[DEPTH].hits;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (fire)
                begin
                    tally_next    = tally_new;
                    overflow_next = overflow_new;
                    if (above_reg)
                    begin
                        fill_level_next = '0;
                        running_next    = '0;
                        frozen_next     = 1'b0;
                    end
                    else if (update_reg)
                    begin
                        running_next = p_reg;
                        if (store_ok)
                        begin
                            fill_level_next = fill_level_reg + FW'(1);
                        end
                        else
                        begin
                            frozen_next = 1'b1;
                        end
                    end
                    if (last_reg)
                    begin
                        out_data_next.match_count      = tally_new;
                        out_data_next.segment_overflow = overflow_new;
                        out_valid_next  = 1'b1;
                        tally_next      = '0;
                        overflow_next   = 1'b0;
                        fill_level_next = '0;
                        running_next    = '0;
                        frozen_next     = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            target_reg     <= '0;
            bound_reg      <= 32'sh7FFF_FFFF;
            fill_level_reg <= '0;
            running_reg    <= '0;
            tally_reg      <= '0;
            overflow_reg   <= 1'b0;
            frozen_reg     <= 1'b0;
            launch_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            target_reg     <= target_next;
            bound_reg      <= bound_next;
            fill_level_reg <= fill_level_next;
            running_reg    <= running_next;
            tally_reg      <= tally_next;
            overflow_reg   <= overflow_next;
            frozen_reg     <= frozen_next;
            launch_reg     <= launch_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg        <= p_next;
        want_reg     <= want_next;
        hits_reg     <= hits_next;
        last_reg     <= last_next;
        update_reg   <= update_next;
        above_reg    <= above_next;
        out_data_reg <= out_data_next;
    end

    // The token enters the chain in the same cycle that the search value is ready.
    assign tok_chain[0].tok  = launch_reg;
    assign tok_chain[0].hits = hits_reg;
    assign pre_chain[0]      = p_reg;

    // Newest prefix sits in cell 0; older ones shift toward the far end.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign live[i] = fill_level_reg > FW'(i);

        if (i == DEPTH - 1)
        begin : g_tail
            bmssc_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift_en  (shift_en),
                .shift_in  (pre_chain[i]),
                .shift_out (),
                .want      (want_reg),
                .live      (live[i]),
                .tok_in    (tok_chain[i]),
                .tok_out   (tok_chain[i+1])
            );
        end
        else
        begin : g_body
            bmssc_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift_en  (shift_en),
                .shift_in  (pre_chain[i]),
                .shift_out (pre_chain[i+1]),
                .want      (want_reg),
                .live      (live[i]),
                .tok_in    (tok_chain[i]),
                .tok_out   (tok_chain[i+1])
            );
        end
    end

endmodule

// ----- hw/rtl/bmssc_checker.sv -----
// Port-level assertions for the bounded subarray-sum counter, with their bind.
module bmssc_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input bmssc_pkg::out_item_t out_data
);

    // A held result keeps its value until the transaction completes.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    // One element is worked on at a time, so ready drops after each input transaction.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an element is still in progress");

    // A result is only produced while an element is being finished.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without an element in progress");

endmodule

bind bounded_max_subarray_sum_counter bmssc_checker u_bmssc_checker (.*);

// ----- bench/tb_bounded_max_subarray_sum_counter.sv -----
// Self-checking testbench for the bounded subarray-sum counter.
`timescale 1ns / 1ps

module tb_bounded_max_subarray_sum_counter;

    // The cycle limit is far above the slowest legal run. That run has every element
    // paying the full chain walk plus the longest sender gap and receiver stall.
    localparam int CYCLE_LIMIT  = 5_000_000;
    localparam int RANDOM_ITEMS = 950;
    localparam int PHASE_ITEMS  = 150;
    // One compared element walks the whole chain. After the last result has come,
    // this many cycles let any element that makes no result finish as well.
    localparam int SETTLE_CYCLES = bmssc_pkg::SEGMENT_DEPTH + 8;
    localparam int MAX_REPORTS   = 10;

    localparam int              ELEM_MAX   = 32'sh7FFF_FFFF;
    localparam int              ELEM_MIN   = 32'sh8000_0000;
    localparam longint          TARGET_MAX = 64'sh0000_007F_FFFF_FFFF;
    localparam longint          TARGET_MIN = 64'shFFFF_FF80_0000_0000;
    localparam longint unsigned TALLY_MAX  = (64'd1 << bmssc_pkg::TALLY_W) - 1;

    // Ways of filling the elements of one random array.
    typedef enum int
    {
        SMALL_MIX,
        TERNARY,
        FULL_RANGE,
        NEAR_LIMITS,
        SPIKY
    } fill_style_t;

    logic                                clk;
    logic                                rst_n     = 1'b0;
    logic                                in_valid  = 1'b0;
    logic                                in_ready;
    bmssc_pkg::in_item_t                 in_data   = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    bmssc_pkg::out_item_t                out_data;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [bmssc_pkg::CFG_INDEX_W-1:0]   cfg_index = bmssc_pkg::CFG_TARGET_SUM;
    logic [bmssc_pkg::TARGET_W-1:0]      cfg_data  = '0;

    bounded_max_subarray_sum_counter dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Elements waiting to be sent, and the counts that are still owed by the block.
    bmssc_pkg::in_item_t  pending_elements[$];
    bmssc_pkg::out_item_t expected_counts[$];

    int queued_items   = 0;
    int accepted_items = 0;
    int results_seen   = 0;
    int overflow_hits  = 0;
    int nonzero_counts = 0;
    int settings_used  = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    // Private copy of the block's state, advanced once per accepted element.
    longint          seg_prefix[bmssc_pkg::SEGMENT_DEPTH];
    int              seg_fill       = 0;
    longint          seg_sum        = 0;
    bit              seg_frozen     = 1'b0;
    longint unsigned array_tally    = 0;
    bit              array_overflow = 1'b0;
    longint          target_now     = 0;
    longint          bound_now      = ELEM_MAX;

    int              burst_left     = 0;
    int              gap_left       = 0;
    logic [31:0]     stall_pattern  = '1;
    int              pattern_age    = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Advance the predicted state by one element. A final element queues the count
    // for its array, and then the array state starts over.
    function automatic void absorb_element(input bmssc_pkg::in_item_t item);
        longint               value;
        longint               prefix;
        longint               wanted;
        longint unsigned      hits;
        bmssc_pkg::out_item_t count_item;
        int                   idx;
        value = $signed(item.element_value);
        if (value > bound_now)
        begin
            // An element above the bound ends the segment and is never counted.
            seg_fill   = 0;
            seg_sum    = 0;
            seg_frozen = 1'b0;
        end
        else if (!seg_frozen)
        begin
            prefix = seg_sum + value;
            wanted = prefix - target_now;
            hits   = (prefix == target_now) ? 1 : 0;
            for (idx = 0; idx < seg_fill; idx++)
            begin
                if (seg_prefix[idx] == wanted)
                begin
                    hits++;
                end
            end
            if (hits > TALLY_MAX - array_tally)
            begin
                array_tally = TALLY_MAX;
            end
            else
            begin
                array_tally += hits;
            end
            seg_sum = prefix;
            if (seg_fill < bmssc_pkg::SEGMENT_DEPTH)
            begin
                seg_prefix[seg_fill] = prefix;
                seg_fill++;
            end
            else
            begin
                // The store is full. This element still counted its matches, but
                // the rest of the segment counts nothing.
                array_overflow = 1'b1;
                seg_frozen     = 1'b1;
            end
        end
        if (item.is_final)
        begin
            count_item.match_count      = array_tally[bmssc_pkg::TALLY_W-1:0];
            count_item.segment_overflow = array_overflow;
            expected_counts.push_back(count_item);
            seg_fill       = 0;
            seg_sum        = 0;
            seg_frozen     = 1'b0;
            array_tally    = 0;
            array_overflow = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("[%0t] MISMATCH: %s", $realtime, what);
        end
    endtask

    // Sender. It works in bursts of random length. Between bursts it leaves gaps that
    // are mostly short and sometimes longer than a whole chain walk, so the gaps land
    // on every phase of the block's work. Valid stays high until the transaction
    // completes. The reference state advances on the edge where the element is
    // accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_data    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                absorb_element(in_data);
                accepted_items++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_elements.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_elements.pop_front();
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        if ($urandom_range(0, 99) < 50)
                        begin
                            gap_left = 0;
                        end
                        else if ($urandom_range(0, 99) < 70)
                        begin
                            gap_left = $urandom_range(1, 4);
                        end
                        else
                        begin
                            gap_left = $urandom_range(5, bmssc_pkg::SEGMENT_DEPTH + 14);
                        end
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver. Ready follows a rotating 32-bit pattern that is drawn again each time it
    // has rotated all the way round. The pattern is always ready, random, or mostly stalled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready     <= 1'b0;
            stall_pattern = '1;
            pattern_age   = 0;
        end
        else
        begin
            if (pattern_age == 31)
            begin
                pattern_age = 0;
                case ($urandom_range(0, 3))
                    0:       stall_pattern = '1;
                    3:       stall_pattern = $urandom() & $urandom() & $urandom();
                    default: stall_pattern = $urandom();
                endcase
            end
            else
            begin
                pattern_age++;
                stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
            end
            out_ready <= stall_pattern[0];
        end
    end

    // Monitor. Each completed output transaction is checked against the oldest count
    // still owed.
    always @(posedge clk)
    begin : count_monitor
        bmssc_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_counts.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result count=%0d overflow=%0b",
                                          out_data.match_count, out_data.segment_overflow));
            end
            else
            begin
                want = expected_counts.pop_front();
                results_seen++;
                if (out_data.segment_overflow === 1'b1)
                begin
                    overflow_hits++;
                end
                if (out_data.match_count != 0)
                begin
                    nonzero_counts++;
                end
                if (out_data.match_count !== want.match_count ||
                    out_data.segment_overflow !== want.segment_overflow)
                begin
                    report_mismatch($sformatf(
                        "result %0d: expected count=%0d overflow=%0b, got count=%0d overflow=%0b",
                        results_seen, want.match_count, want.segment_overflow,
                        out_data.match_count, out_data.segment_overflow));
                end
            end
        end
    end

    // The timeout guards against a block that stops accepting transactions or stops
    // producing results.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic queue_element(input int value, input bit last);
        bmssc_pkg::in_item_t item;
        item.element_value = value;
        item.is_final      = last;
        pending_elements.push_back(item);
        queued_items++;
    endtask

    // Wait until every queued element has been accepted and every count has arrived.
    // Then allow a full chain walk, so that an element which makes no result has
    // finished too.
    task automatic wait_idle();
        while (accepted_items != queued_items || expected_counts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write transaction. The predictor takes the new value on the
    // accepting edge.
    task automatic write_register(input logic [bmssc_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [bmssc_pkg::TARGET_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == bmssc_pkg::CFG_TARGET_SUM)
        begin
            target_now = $signed(value);
        end
        else
        begin
            bound_now = $signed(value[bmssc_pkg::ELEM_W-1:0]);
        end
    endtask

    // Registers should change only while the block is idle, and the block does not enforce
    // that itself, so the sender holds off here until every count has come back.
    task automatic apply_settings(input longint target, input longint bound);
        wait_idle();
        write_register(bmssc_pkg::CFG_TARGET_SUM, bmssc_pkg::TARGET_W'(target));
        write_register(bmssc_pkg::CFG_MAX_BOUND, bmssc_pkg::TARGET_W'(bound));
        settings_used++;
    endtask

    initial
    begin : stimulus
        int                             random_items;
        int                             phase_items;
        int                             len;
        int                             k;
        int                             value;
        fill_style_t                    style;
        logic [bmssc_pkg::TARGET_W-1:0] raw_target;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values: target zero with an open bound. This covers a single zero
        // element, the element extremes, and zero-sum runs.
        queue_element(0, 1'b1);
        queue_element(ELEM_MAX, 1'b0);
        queue_element(ELEM_MIN, 1'b0);
        queue_element(1, 1'b1);
        queue_element(5, 1'b0);
        queue_element(-5, 1'b0);
        queue_element(0, 1'b0);
        queue_element(0, 1'b1);

        // A tight bound splits the array. The last array is a single final element
        // above the bound.
        apply_settings(3, 2);
        queue_element(1, 1'b0);
        queue_element(2, 1'b0);
        queue_element(7, 1'b0);
        queue_element(1, 1'b0);
        queue_element(2, 1'b1);
        queue_element(3, 1'b1);

        // The lowest bound lets only the most negative element through.
        apply_settings(ELEM_MIN, ELEM_MIN);
        queue_element(ELEM_MIN, 1'b0);
        queue_element(0, 1'b0);
        queue_element(ELEM_MIN, 1'b0);
        queue_element(ELEM_MIN, 1'b1);

        // Target extremes, which no short sum can reach.
        apply_settings(TARGET_MAX, ELEM_MAX);
        queue_element(ELEM_MAX, 1'b0);
        queue_element(ELEM_MAX, 1'b1);
        apply_settings(TARGET_MIN, ELEM_MAX);
        queue_element(ELEM_MIN, 1'b0);
        queue_element(ELEM_MIN, 1'b1);

        // A segment that exactly fills the prefix store has no overflow.
        apply_settings(0, ELEM_MAX);
        repeat (bmssc_pkg::SEGMENT_DEPTH - 1) queue_element(0, 1'b0);
        queue_element(0, 1'b1);

        // One element too many overflows the store and freezes the segment. An
        // element above the bound ends the frozen segment, and counting resumes.
        apply_settings(0, 0);
        repeat (bmssc_pkg::SEGMENT_DEPTH + 2) queue_element(0, 1'b0);
        queue_element(1, 1'b0);
        queue_element(0, 1'b0);
        queue_element(0, 1'b1);

        // Random phases. Each phase draws new register values and then sends arrays
        // of random length and content. Small targets and bounds dominate so that
        // matches and segment splits are frequent.
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                6:
                begin
                    apply_settings(0, ELEM_MAX);
                end
                7:
                begin
                    raw_target = {8'($urandom()), 32'($urandom())};
                    apply_settings($signed(raw_target), int'($urandom()));
                end
                8:
                begin
                    apply_settings(int'($urandom()), ELEM_MAX);
                end
                9:
                begin
                    apply_settings($urandom_range(0, 1) ? TARGET_MAX : TARGET_MIN,
                                   $urandom_range(0, 1) ? ELEM_MAX : ELEM_MIN);
                end
                default:
                begin
                    apply_settings(int'($urandom_range(0, 8)) - 4,
                                   int'($urandom_range(0, 8)) - 2);
                end
            endcase
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12)
                                                   : $urandom_range(13, 60);
                k = $urandom_range(0, 19);
                if (k < 10)
                begin
                    style = SMALL_MIX;
                end
                else if (k < 13)
                begin
                    style = TERNARY;
                end
                else if (k < 16)
                begin
                    style = FULL_RANGE;
                end
                else if (k < 18)
                begin
                    style = NEAR_LIMITS;
                end
                else
                begin
                    style = SPIKY;
                end
                for (k = 0; k < len; k++)
                begin
                    case (style)
                        TERNARY:
                        begin
                            value = int'($urandom_range(0, 2)) - 1;
                        end
                        FULL_RANGE:
                        begin
                            value = $urandom();
                        end
                        NEAR_LIMITS:
                        begin
                            case ($urandom_range(0, 4))
                                0:       value = ELEM_MIN;
                                1:       value = ELEM_MAX;
                                2:       value = ELEM_MIN + 1;
                                3:       value = ELEM_MAX - 1;
                                default: value = 0;
                            endcase
                        end
                        SPIKY:
                        begin
                            value = ($urandom_range(0, 99) < 85)
                                    ? int'($urandom_range(0, 8)) - 4 : int'($urandom());
                        end
                        default:
                        begin
                            value = int'($urandom_range(0, 8)) - 4;
                        end
                    endcase
                    queue_element(value, k == len - 1);
                end
                phase_items += len;
            end
            random_items += phase_items;
        end

        wait_idle();

        $display("Ran %0d elements in %0d arrays under %0d register settings.",
                 accepted_items, results_seen, settings_used);
        $display("%0d arrays overflowed the prefix store and %0d had matches; %0d mismatches.",
                 overflow_hits, nonzero_counts, mismatch_count);
        if (mismatch_count == 0 && expected_counts.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/bmssc_pkg.sv
hw/rtl/bmssc_cell.sv
hw/rtl/bounded_max_subarray_sum_counter.sv
hw/rtl/bmssc_checker.sv
bench/tb_bounded_max_subarray_sum_counter.sv
